// File: hdl/btdhc_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// btdhc_pkg
// Shared types and codes for the button tap / double-tap / hold classifier.
// ----------------------------------------------------------------------------
package btdhc_pkg;

  localparam int TIME_W  = 32;
  localparam int DELAY_W = 16;
  localparam int CFG_IDX_W = 2;

  typedef logic [1:0]         opcode_t;
  typedef logic [1:0]         command_t;
  typedef logic [TIME_W-1:0]  ms_t;
  typedef logic [DELAY_W-1:0] delay_t;
  typedef logic [CFG_IDX_W-1:0] cfg_idx_t;

  // Input item kinds
  localparam opcode_t OP_PRESS   = 2'd0;
  localparam opcode_t OP_RELEASE = 2'd1;
  localparam opcode_t OP_TICK    = 2'd2;

  // Result codes
  localparam command_t CMD_HOLD   = 2'd0;
  localparam command_t CMD_DOUBLE = 2'd1;
  localparam command_t CMD_HINT   = 2'd2;
  localparam command_t CMD_SINGLE = 2'd3;

  // Configuration register indexes
  localparam cfg_idx_t REG_HOLD_DELAY = 2'd0;
  localparam cfg_idx_t REG_DTAP_WIN   = 2'd1;

  localparam delay_t HOLD_DELAY_RST = 16'd500;
  localparam delay_t DTAP_WIN_RST   = 16'd300;

endpackage

// File: hdl/button_tap_double_hold_classifier.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// button_tap_double_hold_classifier
// Classifies one button's timestamped down/up/tick words into hold,
// double-tap, single-tap hint and confirmed single-tap commands.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_*): one word per event; s_tuser carries the event kind
//   (press, release, tick), s_tdata the 32-bit millisecond timestamp.
//   Output stream (m_*): zero or one command word per input word, command
//   code in the low bits of m_tdata.
//   Config channel (cfg_*): index 0 hold delay, index 1 double-tap window,
//   both in ms; always ready, write only while the block is idle.
// Timing:
//   A word taken into the input register is classified when the classify
//   stage advances, and its command (if any) lands in the output register.
//   One word per cycle is sustained while the output is not stalled; the
//   single classify stage (32-bit subtract and compare) sets that rate.
// Reset: rst (sync, active high) clears the button state and the pipeline
//   and loads 500 ms hold delay and 300 ms window.
// Stall: while a command waits on m_tready, the input register holds and
//   s_tready drops once it is full; no word is lost or repeated.
// ----------------------------------------------------------------------------
module button_tap_double_hold_classifier
  import btdhc_pkg::*;
(
  input  logic        clk,
  input  logic        rst,
  // input stream
  input  logic        s_tvalid,
  output logic        s_tready,
  input  logic [31:0] s_tdata,   // [31:0] now_ms
  input  logic [1:0]  s_tuser,   // [1:0] opcode
  // output stream
  output logic        m_tvalid,
  input  logic        m_tready,
  output logic [7:0]  m_tdata,   // [1:0] command, [7:2] zero
  // configuration writes
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [1:0]  cfg_index,
  input  logic [15:0] cfg_data
);

  // configuration
  delay_t hold_delay_ms;
  delay_t double_tap_window_ms;

  // button state
  logic key_is_down,        key_is_down_next;
  ms_t  press_time,         press_time_next;
  logic hold_reported,      hold_reported_next;
  logic tap_pending,        tap_pending_next;
  ms_t  pending_since,      pending_since_next;
  ms_t  last_release_time,  last_release_time_next;
  logic last_release_valid, last_release_valid_next;

  // input register
  logic    s1_valid;
  opcode_t s1_op;
  ms_t     s1_now;
  logic    s1_go;

  // classify results
  logic     res_valid;
  command_t res_cmd;
  command_t out_cmd;

  ms_t  press_base;
  ms_t  press_elapsed;
  ms_t  release_elapsed;
  ms_t  pending_elapsed;
  logic press_long;

  assign cfg_ready = 1'b1;

  // config register writes
  always_ff @(posedge clk) begin
    if (rst) begin
      hold_delay_ms        <= HOLD_DELAY_RST;
      double_tap_window_ms <= DTAP_WIN_RST;
    end else if (cfg_valid && cfg_ready) begin
      case (cfg_index)
        REG_HOLD_DELAY: hold_delay_ms        <= cfg_data;
        REG_DTAP_WIN:   double_tap_window_ms <= cfg_data;
        default: ;
      endcase
    end
  end

  // handshake: classify stage advances when the output register is free
  assign s1_go    = s1_valid && (!m_tvalid || m_tready);
  assign s_tready = !s1_valid || s1_go;

  // input register
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s_tready) begin
      s1_valid <= s_tvalid;
    end
  end

  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      s1_op  <= s_tuser;
      s1_now <= s_tdata;
    end
  end

  // elapsed times, modulo 2^32
  assign press_base      = key_is_down ? press_time : s1_now;
  assign press_elapsed   = s1_now - press_base;
  assign release_elapsed = s1_now - last_release_time;
  assign pending_elapsed = s1_now - pending_since;
  assign press_long      = press_elapsed >= {{(TIME_W-DELAY_W){1'b0}}, hold_delay_ms};

  // classify one word
  always_comb begin
    key_is_down_next        = key_is_down;
    press_time_next         = press_time;
    hold_reported_next      = hold_reported;
    tap_pending_next        = tap_pending;
    pending_since_next      = pending_since;
    last_release_time_next  = last_release_time;
    last_release_valid_next = last_release_valid;
    res_valid               = 1'b0;
    res_cmd                 = CMD_HOLD;
    case (s1_op)
      OP_PRESS: begin
        // first down of a press starts the timer
        if (!key_is_down) begin
          key_is_down_next   = 1'b1;
          press_time_next    = s1_now;
          hold_reported_next = 1'b0;
        end
        if ((!key_is_down || !hold_reported) && press_long) begin
          hold_reported_next      = 1'b1;
          tap_pending_next        = 1'b0;
          last_release_valid_next = 1'b0;
          res_valid               = 1'b1;
          res_cmd                 = CMD_HOLD;
        end
      end
      OP_RELEASE: begin
        if (key_is_down) begin
          key_is_down_next = 1'b0;
          if (hold_reported) begin
            // release after a hold: silent
            hold_reported_next      = 1'b0;
            last_release_valid_next = 1'b0;
          end else if (press_long) begin
            // long release: silent
            last_release_valid_next = 1'b0;
          end else if (last_release_valid &&
                       release_elapsed <= {{(TIME_W-DELAY_W){1'b0}},
                                           double_tap_window_ms}) begin
            tap_pending_next       = 1'b0;
            last_release_time_next = s1_now;
            res_valid              = 1'b1;
            res_cmd                = CMD_DOUBLE;
          end else begin
            tap_pending_next        = 1'b1;
            pending_since_next      = s1_now;
            last_release_time_next  = s1_now;
            last_release_valid_next = 1'b1;
            res_valid               = 1'b1;
            res_cmd                 = CMD_HINT;
          end
        end
      end
      OP_TICK: begin
        if (tap_pending &&
            pending_elapsed >= {{(TIME_W-DELAY_W){1'b0}}, double_tap_window_ms}) begin
          tap_pending_next = 1'b0;
          res_valid        = 1'b1;
          res_cmd          = CMD_SINGLE;
        end
      end
      default: ;
    endcase
  end

  // button state update
  always_ff @(posedge clk) begin
    if (rst) begin
      key_is_down        <= 1'b0;
      press_time         <= '0;
      hold_reported      <= 1'b0;
      tap_pending        <= 1'b0;
      pending_since      <= '0;
      last_release_time  <= '0;
      last_release_valid <= 1'b0;
    end else if (s1_go) begin
      key_is_down        <= key_is_down_next;
      press_time         <= press_time_next;
      hold_reported      <= hold_reported_next;
      tap_pending        <= tap_pending_next;
      pending_since      <= pending_since_next;
      last_release_time  <= last_release_time_next;
      last_release_valid <= last_release_valid_next;
    end
  end

  // output register
  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (s1_go && res_valid) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_go && res_valid) begin
      out_cmd <= res_cmd;
    end
  end

  assign m_tdata = {6'd0, out_cmd};

`ifndef SYNTH
  // a hold can only be reported while the key is down
  a_hold_needs_down: assert property (@(posedge clk) disable iff (rst)
    hold_reported |-> key_is_down)
    else $error("hold_reported set with key up");

  // a stalled command never gets overwritten by the classify stage
  a_no_overrun: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |-> !s1_go)
    else $error("classify stage advanced over a stalled command");

  // a hold result marks the press as reported
  a_hold_marks: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res_valid && res_cmd == CMD_HOLD) |=> hold_reported)
    else $error("hold emitted without marking press");

  // a hint opens the pending window and validates the release
  a_hint_opens: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res_valid && res_cmd == CMD_HINT) |=>
      (tap_pending && last_release_valid && !key_is_down))
    else $error("hint without pending window");

  // a confirmed single tap closes the pending window
  a_single_closes: assert property (@(posedge clk) disable iff (rst)
    (s1_go && res_valid && res_cmd == CMD_SINGLE) |=> !tap_pending)
    else $error("single tap left window pending");
`endif

endmodule

// File: tb/sv/gesture_scoreboard_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// gesture_scoreboard_pkg
// Predicts the command words of the button classifier from the accepted
// event words and checks the block's output against them in order.
// ----------------------------------------------------------------------------
package gesture_scoreboard_pkg;
  import btdhc_pkg::*;

  class gesture_scoreboard;
    // configuration copy
    delay_t   hold_delay;
    delay_t   tap_window;
    // button state copy
    bit       key_down;
    bit       hold_seen;
    bit       tap_open;
    bit       release_valid;
    ms_t      press_at;
    ms_t      open_since;
    ms_t      release_at;
    // commands the block still owes us
    command_t expected_cmds[$];
    int       errors;

    function new();
      hold_delay    = HOLD_DELAY_RST;
      tap_window    = DTAP_WIN_RST;
      key_down      = 1'b0;
      hold_seen     = 1'b0;
      tap_open      = 1'b0;
      release_valid = 1'b0;
      press_at      = '0;
      open_since    = '0;
      release_at    = '0;
      errors        = 0;
    endfunction

    function int outstanding();
      return expected_cmds.size();
    endfunction

    function void set_register(cfg_idx_t idx, delay_t value);
      case (idx)
        REG_HOLD_DELAY: hold_delay = value;
        REG_DTAP_WIN:   tap_window = value;
        default: ;
      endcase
    endfunction

    // Advance the button state by one accepted event word
    function void take_event(opcode_t op, ms_t now);
      ms_t held;
      ms_t since_release;
      ms_t since_open;
      case (op)
        OP_PRESS: begin
          // first down of a press latches the press time
          if (!key_down) begin
            key_down  = 1'b1;
            press_at  = now;
            hold_seen = 1'b0;
          end
          held = now - press_at;
          if (!hold_seen && held >= ms_t'(hold_delay)) begin
            hold_seen     = 1'b1;
            tap_open      = 1'b0;
            release_valid = 1'b0;
            expected_cmds.push_back(CMD_HOLD);
          end
        end
        OP_RELEASE: begin
          if (key_down) begin
            key_down      = 1'b0;
            held          = now - press_at;
            since_release = now - release_at;
            if (hold_seen) begin
              hold_seen     = 1'b0;
              release_valid = 1'b0;
            end else if (held >= ms_t'(hold_delay)) begin
              release_valid = 1'b0;
            end else if (release_valid && since_release <= ms_t'(tap_window)) begin
              tap_open   = 1'b0;
              release_at = now;
              expected_cmds.push_back(CMD_DOUBLE);
            end else begin
              tap_open      = 1'b1;
              open_since    = now;
              release_at    = now;
              release_valid = 1'b1;
              expected_cmds.push_back(CMD_HINT);
            end
          end
        end
        OP_TICK: begin
          since_open = now - open_since;
          if (tap_open && since_open >= ms_t'(tap_window)) begin
            tap_open = 1'b0;
            expected_cmds.push_back(CMD_SINGLE);
          end
        end
        default: ;
      endcase
    endfunction

    task report_mismatch(string msg);
      $display("ERROR @%0t: %s", $realtime, msg);
      errors++;
    endtask

    // Compare one output word with the oldest predicted command
    task check_command(command_t got);
      command_t want;
      if (expected_cmds.size() == 0) begin
        report_mismatch($sformatf("command %0d with nothing expected", got));
      end else begin
        want = expected_cmds.pop_front();
        if (got !== want)
          report_mismatch($sformatf("command %0d, expected %0d", got, want));
      end
    endtask

    task check_empty();
      if (expected_cmds.size() != 0)
        report_mismatch($sformatf("%0d commands never arrived", expected_cmds.size()));
    endtask
  endclass

endpackage

// File: tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Drives timestamped press/release/tick words into the button classifier
// under random stalls on both streams, across several delay and window
// settings, and checks every command word against the scoreboard.
// ----------------------------------------------------------------------------
module testbench;
  import btdhc_pkg::*;
  import gesture_scoreboard_pkg::*;

  localparam int      CLK_PERIOD       = 12;
  localparam int      RESET_CYCLES     = 9;
  localparam int      LONG_HOLD_CYCLES = 200;
  localparam int      WORD_TARGET      = 850;
  localparam int      NUM_PHASES       = 8;
  localparam int      SETTLE_CYCLES    = 6;
  localparam int      DRAIN_LIMIT      = 20000;
  localparam longint  TIMEOUT_NS       = 64'd5_000_000;
  localparam opcode_t OP_UNUSED        = 2'd3;

  logic        clk;
  logic        rst;
  logic        s_tvalid;
  logic        s_tready;
  logic [31:0] s_tdata;    // [31:0] now_ms
  logic [1:0]  s_tuser;    // [1:0] opcode
  logic        m_tvalid;
  logic        m_tready;
  logic [7:0]  m_tdata;    // [1:0] command, [7:2] zero
  logic        cfg_valid;
  logic        cfg_ready;
  logic [1:0]  cfg_index;
  logic [15:0] cfg_data;

  gesture_scoreboard sb;
  ms_t    clock_ms;
  delay_t cur_hold;
  delay_t cur_win;
  int     words_sent;
  bit     calm;
  bit     long_hold;

  button_tap_double_hold_classifier uut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .s_tuser  (s_tuser),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_valid(cfg_valid),
    .cfg_ready(cfg_ready),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // clock
  initial begin
    clk = 1'b0;
    forever #(CLK_PERIOD / 2) clk = ~clk;
  end

  // run limit
  initial begin
    #(TIMEOUT_NS);
    $display("FAIL button_tap_double_hold_classifier");
    $finish;
  end

  // handshake monitor: config writes, accepted events, output words
  always @(posedge clk) begin
    if (!rst) begin
      if (cfg_valid && cfg_ready) sb.set_register(cfg_index, cfg_data);
      if (s_tvalid && s_tready) sb.take_event(s_tuser, s_tdata);
      if (m_tvalid && m_tready) sb.check_command(m_tdata[1:0]);
    end
  end

  // output side: random stall bursts, one long hold-off on request
  initial begin
    m_tready = 1'b0;
    forever begin
      @(negedge clk);
      if (long_hold) begin
        m_tready <= 1'b0;
        repeat (LONG_HOLD_CYCLES) @(negedge clk);
        long_hold = 1'b0;
        m_tready <= 1'b1;
      end else if (!calm && $urandom_range(0, 5) == 0) begin
        m_tready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(negedge clk);
        m_tready <= 1'b1;
      end else begin
        m_tready <= 1'b1;
      end
    end
  end

  // offer one event word and wait for it to be taken, then maybe idle
  task send_word(opcode_t op, ms_t now);
    @(negedge clk);
    s_tvalid <= 1'b1;
    s_tuser  <= op;
    s_tdata  <= now;
    do @(posedge clk); while (!s_tready);
    if (op != OP_UNUSED) words_sent++;
    if (!calm && $urandom_range(0, 5) == 0) begin
      @(negedge clk);
      s_tvalid <= 1'b0;
      repeat ($urandom_range(0, 18)) @(negedge clk);
    end
  endtask

  // stop sending and wait until every predicted command has come out
  task settle();
    int guard;
    guard = 0;
    @(negedge clk);
    s_tvalid <= 1'b0;
    while (sb.outstanding() != 0 && guard < DRAIN_LIMIT) begin
      @(negedge clk);
      guard++;
    end
    repeat (SETTLE_CYCLES) @(negedge clk);
  endtask

  task write_reg(cfg_idx_t idx, delay_t value);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
  endtask

  task configure(delay_t hold, delay_t win);
    settle();
    write_reg(REG_HOLD_DELAY, hold);
    write_reg(REG_DTAP_WIN, win);
    cur_hold = hold;
    cur_win  = win;
  endtask

  // offsets clustered around a threshold, with some wide ones
  function ms_t near(int unsigned base);
    case ($urandom_range(0, 7))
      0:       near = ms_t'(base) - 1;
      1:       near = ms_t'(base);
      2:       near = ms_t'(base) + 1;
      3, 4:    near = $urandom_range(0, 2 * base + 2);
      5, 6:    near = $urandom_range(0, 40);
      default: near = $urandom;
    endcase
  endfunction

  // press, a few autorepeats, release
  task tap_gesture();
    ms_t t0;
    t0 = clock_ms;
    send_word(OP_PRESS, t0);
    repeat ($urandom_range(0, 3)) send_word(OP_PRESS, t0 + near(cur_hold));
    if ($urandom_range(0, 2) == 0)
      clock_ms = t0 + near(cur_hold);
    else
      clock_ms = t0 + ms_t'($urandom_range(0, cur_hold));
    send_word(OP_RELEASE, clock_ms);
  endtask

  task random_gesture();
    case ($urandom_range(0, 9))
      0, 1, 2, 3, 4: begin
        tap_gesture();
        if ($urandom_range(0, 1)) send_word(OP_TICK, clock_ms + near(cur_win));
        clock_ms = clock_ms + near(cur_win);
      end
      5, 6: send_word(OP_TICK, clock_ms + near(cur_win));
      7: begin
        // two quick taps aimed at the double-tap window
        tap_gesture();
        clock_ms = clock_ms + ms_t'($urandom_range(0, cur_win / 2));
        tap_gesture();
        clock_ms = clock_ms + near(cur_win);
      end
      default: begin
        if ($urandom_range(0, 1))
          send_word(opcode_t'($urandom_range(0, 3)), $urandom);
        else
          send_word(opcode_t'($urandom_range(0, 3)), clock_ms + near(cur_win));
      end
    endcase
  endtask

  // corner cases at fixed settings
  task directed();
    ms_t t;
    t = 32'hFFFF_FFC0;
    send_word(OP_TICK, t);               // tick with no tap pending
    send_word(OP_RELEASE, t);            // release while up
    send_word(OP_UNUSED, 32'h0);         // unused opcode
    send_word(OP_PRESS, t);
    send_word(OP_RELEASE, t + 100);      // short release across the wrap: hint
    send_word(OP_TICK, t + 150);
    send_word(OP_PRESS, t + 200);
    send_word(OP_RELEASE, t + 250);      // double tap
    send_word(OP_PRESS, t + 1000);
    send_word(OP_PRESS, t + 1499);
    send_word(OP_PRESS, t + 1500);       // hold
    send_word(OP_PRESS, t + 1600);
    send_word(OP_RELEASE, t + 1700);     // release after hold
    send_word(OP_PRESS, t + 2000);
    send_word(OP_RELEASE, t + 2500);     // long release
    send_word(OP_PRESS, t + 3000);
    send_word(OP_RELEASE, t + 3100);
    send_word(OP_TICK, t + 3399);
    send_word(OP_TICK, t + 3400);        // window elapsed: single tap
    send_word(OP_PRESS, 32'hFFFF_FFFF);
    send_word(OP_RELEASE, 32'h0);
    // zero hold delay: first down holds at once
    configure(16'd0, 16'd0);
    send_word(OP_PRESS, 32'd5);
    send_word(OP_RELEASE, 32'd5);
    // zero window
    configure(16'hFFFF, 16'd0);
    send_word(OP_PRESS, 32'd100);
    send_word(OP_RELEASE, 32'd100);
    send_word(OP_PRESS, 32'd100);
    send_word(OP_RELEASE, 32'd100);      // same timestamp: double tap
    send_word(OP_PRESS, 32'd200);
    send_word(OP_RELEASE, 32'd300);
    send_word(OP_TICK, 32'd300);
  endtask

  // main sequence
  initial begin
    delay_t hold_set [NUM_PHASES];
    delay_t win_set [NUM_PHASES];
    rst        = 1'b1;
    s_tvalid   = 1'b0;
    s_tdata    = '0;
    s_tuser    = '0;
    cfg_valid  = 1'b0;
    cfg_index  = '0;
    cfg_data   = '0;
    calm       = 1'b0;
    long_hold  = 1'b0;
    words_sent = 0;
    cur_hold   = HOLD_DELAY_RST;
    cur_win    = DTAP_WIN_RST;
    sb         = new();

    hold_set = '{16'd500, 16'd0, 16'hFFFF, 16'd0, 16'hFFFF, 16'd40,
                 delay_t'($urandom_range(0, 65535)), 16'd120};
    win_set  = '{16'd300, 16'd0, 16'hFFFF, 16'hFFFF, 16'd0, 16'd25,
                 delay_t'($urandom_range(0, 65535)), 16'd80};

    repeat (RESET_CYCLES) @(negedge clk);
    rst <= 1'b0;

    directed();
    clock_ms = $urandom;

    for (int p = 0; p < NUM_PHASES; p++) begin
      configure(hold_set[p], win_set[p]);
      if (p == 2) begin
        // back up the output while events keep coming
        @(posedge clk);
        long_hold = 1'b1;
      end
      if (p == NUM_PHASES - 1) calm = 1'b1;
      while (words_sent < WORD_TARGET * (p + 1) / NUM_PHASES) random_gesture();
    end

    settle();
    sb.check_empty();
    if (sb.errors == 0)
      $display("PASS button_tap_double_hold_classifier");
    else
      $display("FAIL button_tap_double_hold_classifier");
    $finish;
  end

endmodule

// File: files.f
hdl/btdhc_pkg.sv
hdl/button_tap_double_hold_classifier.sv
tb/sv/gesture_scoreboard_pkg.sv
tb/sv/testbench.sv
